>>> sv/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/vrsp_pkg.sv
`default_nettype none

package vrsp_pkg;

    typedef struct packed {
        logic signed [23:0] in_x;
        logic signed [23:0] in_y;
        logic signed [23:0] in_z;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [31:0] depth;
        logic               depth_invalid;
    } result_t;

    localparam int NUM_REGS = 8;

    localparam logic [2:0] REG_ANGLE_X = 3'd0;
    localparam logic [2:0] REG_ANGLE_Y = 3'd1;
    localparam logic [2:0] REG_ANGLE_Z = 3'd2;
    localparam logic [2:0] REG_SCALE_X = 3'd3;
    localparam logic [2:0] REG_SCALE_Y = 3'd4;
    localparam logic [2:0] REG_SCALE_Z = 3'd5;
    localparam logic [2:0] REG_FOCAL_H = 3'd6;
    localparam logic [2:0] REG_FOCAL_V = 3'd7;

    localparam logic [15:0] SCALE_RESET = 16'd5120;
    localparam logic [15:0] FOCAL_RESET = 16'd4096;

    // coordinate, trig, scaled, numerator, denominator, remainder and quotient widths
    localparam int CW = 27;
    localparam int TW = 18;
    localparam int SW = 36;
    localparam int NW = 57;
    localparam int DW = 35;
    localparam int RW = 36;
    localparam int QW = 32;

    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [27:0] Z_OFFSET  = 28'sd262144;

    function automatic logic signed [31:0] atan_val(input logic [3:0] i);
        logic signed [31:0] v;
        case (i)
            4'd0:    v = 32'sh20000000;
            4'd1:    v = 32'sh12E4051E;
            4'd2:    v = 32'sh09FB385B;
            4'd3:    v = 32'sh051111D4;
            4'd4:    v = 32'sh028B0D43;
            4'd5:    v = 32'sh0145D7E1;
            4'd6:    v = 32'sh00A2F61E;
            4'd7:    v = 32'sh00517C55;
            4'd8:    v = 32'sh0028BE53;
            4'd9:    v = 32'sh00145F2F;
            4'd10:   v = 32'sh000A2F98;
            4'd11:   v = 32'sh000517CC;
            4'd12:   v = 32'sh00028BE6;
            4'd13:   v = 32'sh000145F3;
            4'd14:   v = 32'sh0000A2FA;
            default: v = 32'sh0000517D;
        endcase
        return v;
    endfunction

    // (p - q + 0.5) >> 16 when sub is set, else (p + q + 0.5) >> 16
    function automatic logic signed [CW-1:0] rot_round(input logic signed [44:0] p,
                                                       input logic signed [44:0] q,
                                                       input logic            sub);
        logic signed [45:0] t;
        t = sub ? (46'(p) - 46'(q) + 46'sd32768) : (46'(p) + 46'(q) + 46'sd32768);
        return t[16+CW-1:16];
    endfunction

endpackage

`default_nettype wire

>>> sv/vertex_rotate_scale_project.sv
`default_nettype none

// Vertex rotate / scale / perspective project.
// Config: APB port, 8 x 16-bit registers at byte address 4*i (angles, scales,
// focal factors); pready is always high, reads return the register value.
// Input: a word on vertex is taken at a clock edge with start high and busy low.
// Output: done pulses for one cycle with the result word; the receiver cannot
// stall, so nothing is held back. A new vertex may enter every cycle while busy
// is low. Pipeline: 43 register stages (six rotation stages, scale and focal
// multiplies, divider load, 32 restoring divide stages, output); done and the
// result word are registered together in the output stage.
// Sine/cosine of the three angles come from one iterative CORDIC unit, one angle
// at a time, a load step then its iterations; busy is high while it runs,
// after reset and after any angle write. Other writes take effect at once.
// Reset clears the pipeline valid bits and loads the register defaults.
module vertex_rotate_scale_project import vrsp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    input  vertex_t     vertex,
    output logic        busy,
    output logic        done,
    output result_t     result
);

    localparam int DIV_STEPS = QW;

    typedef enum logic [1:0] {CS_IDLE, CS_LOAD, CS_RUN} cs_state_t;

    typedef struct packed {
        logic [RW-1:0] rem_x;
        logic [QW-1:0] low_x;
        logic [QW-1:0] q_x;
        logic [RW-1:0] rem_y;
        logic [QW-1:0] low_y;
        logic [QW-1:0] q_y;
        logic [DW-1:0] d;
        logic          ovf_x;
        logic          ovf_y;
        logic          neg_x;
        logic          neg_y;
        logic          invalid;
        logic [31:0]   depth;
    } div_t;

    // ---------------- configuration ----------------
    logic [15:0] cfg_reg [NUM_REGS];
    logic        wr_en;
    logic [2:0]  wr_idx;

    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[4:2];
    assign pready = 1'b1;
    assign prdata = {16'd0, cfg_reg[wr_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ANGLE_X] <= 16'd0;
            cfg_reg[REG_ANGLE_Y] <= 16'd0;
            cfg_reg[REG_ANGLE_Z] <= 16'd0;
            cfg_reg[REG_SCALE_X] <= SCALE_RESET;
            cfg_reg[REG_SCALE_Y] <= SCALE_RESET;
            cfg_reg[REG_SCALE_Z] <= SCALE_RESET;
            cfg_reg[REG_FOCAL_H] <= FOCAL_RESET;
            cfg_reg[REG_FOCAL_V] <= FOCAL_RESET;
        end
        else if (wr_en)
        begin
            cfg_reg[wr_idx] <= pwdata[15:0];
        end
    end

    // ---------------- CORDIC sine/cosine unit ----------------
    cs_state_t          cs_state_reg;
    logic [1:0]         cs_idx_reg;
    logic [3:0]         cs_step_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [1:0]         cq_reg;
    logic signed [TW-1:0] cos_reg [3];
    logic signed [TW-1:0] sin_reg [3];

    logic [15:0]        ang;
    logic [15:0]        ang_sum;
    logic [15:0]        ang_res;
    logic signed [32:0] cx_next, cy_next;
    logic signed [31:0] cz_next;
    logic signed [32:0] c_full, s_full, c_rnd, s_rnd;

    always_comb
    begin
        case (cs_idx_reg)
            2'd0:    ang = cfg_reg[REG_ANGLE_X];
            2'd1:    ang = cfg_reg[REG_ANGLE_Y];
            default: ang = cfg_reg[REG_ANGLE_Z];
        endcase
        ang_sum = ang + 16'h2000;
        ang_res = ang - {ang_sum[15:14], 14'd0};
        if (!cz_reg[31])
        begin
            cx_next = cx_reg - (cy_reg >>> cs_step_reg);
            cy_next = cy_reg + (cx_reg >>> cs_step_reg);
            cz_next = cz_reg - atan_val(cs_step_reg);
        end
        else
        begin
            cx_next = cx_reg + (cy_reg >>> cs_step_reg);
            cy_next = cy_reg - (cx_reg >>> cs_step_reg);
            cz_next = cz_reg + atan_val(cs_step_reg);
        end
        case (cq_reg)
            2'd0:    begin c_full = cx_next;  s_full = cy_next;  end
            2'd1:    begin c_full = -cy_next; s_full = cx_next;  end
            2'd2:    begin c_full = -cx_next; s_full = -cy_next; end
            default: begin c_full = cy_next;  s_full = -cx_next; end
        endcase
        c_rnd = c_full + 33'sd8192;
        s_rnd = s_full + 33'sd8192;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_state_reg <= CS_LOAD;
            cs_idx_reg   <= 2'd0;
            cs_step_reg  <= 4'd0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            cz_reg       <= '0;
            cq_reg       <= 2'd0;
            for (int i = 0; i < 3; i++)
            begin
                cos_reg[i] <= '0;
                sin_reg[i] <= '0;
            end
        end
        else if (wr_en && (wr_idx == REG_ANGLE_X || wr_idx == REG_ANGLE_Y
                           || wr_idx == REG_ANGLE_Z))
        begin
            cs_state_reg <= CS_LOAD;
            cs_idx_reg   <= 2'd0;
        end
        else
        begin
            case (cs_state_reg)
                CS_LOAD:
                begin
                    cx_reg       <= CORDIC_X0;
                    cy_reg       <= '0;
                    cz_reg       <= {ang_res, 16'd0};
                    cq_reg       <= ang_sum[15:14];
                    cs_step_reg  <= 4'd0;
                    cs_state_reg <= CS_RUN;
                end
                CS_RUN:
                begin
                    cx_reg      <= cx_next;
                    cy_reg      <= cy_next;
                    cz_reg      <= cz_next;
                    cs_step_reg <= cs_step_reg + 4'd1;
                    if (cs_step_reg == 4'd15)
                    begin
                        cos_reg[cs_idx_reg] <= c_rnd[14+TW-1:14];
                        sin_reg[cs_idx_reg] <= s_rnd[14+TW-1:14];
                        if (cs_idx_reg == 2'd2)
                        begin
                            cs_state_reg <= CS_IDLE;
                        end
                        else
                        begin
                            cs_idx_reg   <= cs_idx_reg + 2'd1;
                            cs_state_reg <= CS_LOAD;
                        end
                    end
                end
                default:
                begin
                    cs_state_reg <= CS_IDLE;
                end
            endcase
        end
    end

    assign busy = (cs_state_reg != CS_IDLE);

    // ---------------- rotation pipeline ----------------
    // v_reg[i] marks the word whose data sits i stages past the m1 registers
    logic [8:0]  v_reg;
    logic        acc;
    assign acc = start & ~busy;

    logic signed [44:0] m1_ac, m1_bs, m1_as, m1_bc;
    logic signed [44:0] m2_ac, m2_bs, m2_as, m2_bc;
    logic signed [44:0] m3_ac, m3_bs, m3_as, m3_bc;
    logic signed [CW-1:0] m1_x, m2_y, m3_z;
    logic signed [CW-1:0] s1_x, s1_y, s1_z;
    logic signed [CW-1:0] s2_x, s2_y, s2_z;
    logic signed [CW-1:0] s3_x, s3_y, s3_z;
    logic signed [CW-1:0] in_xe, in_ye, in_ze;
    logic signed [27:0]   z_off;
    logic signed [43:0]   sc_x, sc_y;
    logic signed [44:0]   sc_z;
    logic signed [44:0]   rx_t, ry_t, rz_t;
    logic signed [SW-1:0] v_x, v_y, v_z;
    logic signed [NW-1:0] f_x, f_y;
    logic signed [52:0]   fx_p, fy_p;
    logic signed [SW-1:0] f_z;
    logic                 f_inv;
    logic [31:0]          f_depth;

    assign in_xe = CW'(vertex.in_x);
    assign in_ye = CW'(vertex.in_y);
    assign in_ze = CW'(vertex.in_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[7:0], acc};
        end
    end

    always_ff @(posedge clk)
    begin
        // about X: pair (y, z)
        m1_ac <= in_ye * cos_reg[0];
        m1_bs <= in_ze * sin_reg[0];
        m1_as <= in_ye * sin_reg[0];
        m1_bc <= in_ze * cos_reg[0];
        m1_x  <= in_xe;
        s1_y  <= rot_round(m1_ac, m1_bs, 1'b1);
        s1_z  <= rot_round(m1_as, m1_bc, 1'b0);
        s1_x  <= m1_x;
        // about Y: pair (z, x)
        m2_ac <= s1_z * cos_reg[1];
        m2_bs <= s1_x * sin_reg[1];
        m2_as <= s1_z * sin_reg[1];
        m2_bc <= s1_x * cos_reg[1];
        m2_y  <= s1_y;
        s2_z  <= rot_round(m2_ac, m2_bs, 1'b1);
        s2_x  <= rot_round(m2_as, m2_bc, 1'b0);
        s2_y  <= m2_y;
        // about Z: pair (x, y)
        m3_ac <= s2_x * cos_reg[2];
        m3_bs <= s2_y * sin_reg[2];
        m3_as <= s2_x * sin_reg[2];
        m3_bc <= s2_y * cos_reg[2];
        m3_z  <= s2_z;
        s3_x  <= rot_round(m3_ac, m3_bs, 1'b1);
        s3_y  <= rot_round(m3_as, m3_bc, 1'b0);
        s3_z  <= m3_z;
        // offset and scale
        sc_x  <= s3_x * $signed({1'b0, cfg_reg[REG_SCALE_X]});
        sc_y  <= s3_y * $signed({1'b0, cfg_reg[REG_SCALE_Y]});
        sc_z  <= z_off * $signed({1'b0, cfg_reg[REG_SCALE_Z]});
        v_x   <= rx_t[8+SW-1:8];
        v_y   <= ry_t[8+SW-1:8];
        v_z   <= rz_t[8+SW-1:8];
        // focal multiply, times 16
        f_x     <= {fx_p, 4'd0};
        f_y     <= {fy_p, 4'd0};
        f_z     <= v_z;
        f_inv   <= (v_z <= 0);
        f_depth <= (v_z > 36'sd2147483647)  ? 32'h7FFFFFFF :
                   (v_z < -36'sd2147483648) ? 32'h80000000 : v_z[31:0];
    end

    always_comb
    begin
        z_off = 28'(s3_z) + Z_OFFSET;
        rx_t  = 45'(sc_x) + 45'sd128;
        ry_t  = 45'(sc_y) + 45'sd128;
        rz_t  = sc_z + 45'sd128;
        fx_p  = v_x * $signed({1'b0, cfg_reg[REG_FOCAL_H]});
        fy_p  = v_y * $signed({1'b0, cfg_reg[REG_FOCAL_V]});
    end

    // ---------------- divide pipeline ----------------
    div_t               div_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] dv_reg;
    logic [NW-1:0]      mag_x, mag_y;
    logic [DW-1:0]      den;

    always_comb
    begin
        mag_x = f_x[NW-1] ? NW'(-f_x) : NW'(f_x);
        mag_y = f_y[NW-1] ? NW'(-f_y) : NW'(f_y);
        den   = f_z[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        div_reg[0].rem_x   <= RW'(mag_x[NW-1:QW]);
        div_reg[0].low_x   <= mag_x[QW-1:0];
        div_reg[0].q_x     <= '0;
        div_reg[0].rem_y   <= RW'(mag_y[NW-1:QW]);
        div_reg[0].low_y   <= mag_y[QW-1:0];
        div_reg[0].q_y     <= '0;
        div_reg[0].d       <= den;
        div_reg[0].ovf_x   <= ({10'd0, mag_x} >= {den, 32'd0});
        div_reg[0].ovf_y   <= ({10'd0, mag_y} >= {den, 32'd0});
        div_reg[0].neg_x   <= f_x[NW-1];
        div_reg[0].neg_y   <= f_y[NW-1];
        div_reg[0].invalid <= f_inv;
        div_reg[0].depth   <= f_depth;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else
        begin
            dv_reg <= {dv_reg[DIV_STEPS-1:0], v_reg[8]};
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [RW-1:0] tx, ty;
        logic          gx, gy;
        div_t          nx;
        always_comb
        begin
            tx = {div_reg[k].rem_x[RW-2:0], div_reg[k].low_x[QW-1]};
            ty = {div_reg[k].rem_y[RW-2:0], div_reg[k].low_y[QW-1]};
            gx = (tx >= {1'b0, div_reg[k].d});
            gy = (ty >= {1'b0, div_reg[k].d});
            nx       = div_reg[k];
            nx.rem_x = gx ? tx - {1'b0, div_reg[k].d} : tx;
            nx.rem_y = gy ? ty - {1'b0, div_reg[k].d} : ty;
            nx.low_x = {div_reg[k].low_x[QW-2:0], 1'b0};
            nx.low_y = {div_reg[k].low_y[QW-2:0], 1'b0};
            nx.q_x   = {div_reg[k].q_x[QW-2:0], gx};
            nx.q_y   = {div_reg[k].q_y[QW-2:0], gy};
        end
        always_ff @(posedge clk)
        begin
            div_reg[k+1] <= nx;
        end
    end

    // ---------------- saturate and output ----------------
    function automatic logic [31:0] sat_q(input logic [QW-1:0] q, input logic neg,
                                          input logic ovf);
        logic [31:0] r;
        if (ovf)
            r = neg ? 32'h80000000 : 32'h7FFFFFFF;
        else if (neg)
            r = (q > 32'h80000000) ? 32'h80000000 : (~q + 32'd1);
        else
            r = q[31] ? 32'h7FFFFFFF : q;
        return r;
    endfunction

    logic    done_reg;
    result_t result_reg;
    div_t    dl;
    assign dl = div_reg[DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.proj_x        <= dl.invalid ? 32'd0 : sat_q(dl.q_x, dl.neg_x, dl.ovf_x);
        result_reg.proj_y        <= dl.invalid ? 32'd0 : sat_q(dl.q_y, dl.neg_y, dl.ovf_y);
        result_reg.depth         <= dl.depth;
        result_reg.depth_invalid <= dl.invalid;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> sv/vrsp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module vrsp_checker import vrsp_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic        busy,
    input logic        done,
    input result_t     result
);

    logic angle_wr;
    assign angle_wr = psel & penable & pwrite &
                      (paddr[4:2] == REG_ANGLE_X || paddr[4:2] == REG_ANGLE_Y ||
                       paddr[4:2] == REG_ANGLE_Z);

    `ASSERT_IMPL(a_inv_zero, clk, rst_n, done && result.depth_invalid, result.proj_x == 0 && result.proj_y == 0)
    `ASSERT_IMPL(a_valid_pos, clk, rst_n, done && !result.depth_invalid, !result.depth[31] && result.depth != 0)
    `ASSERT_IMPL(a_inv_nonpos, clk, rst_n, done && result.depth_invalid, result.depth[31] || result.depth == 0)
    `ASSERT_NEXT(a_angle_busy, clk, rst_n, angle_wr, busy)

endmodule

bind vertex_rotate_scale_project vrsp_checker u_vrsp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire
